// File: rtl/grfc_pkg.sv
// Shared types and constants for the gated reciprocal frequency counter.
package grfc_pkg;

    localparam int CPU_HZ_W = 27;
    localparam int WIN_W    = 16;
    localparam int EDGE_W   = 16;
    localparam int TICK_W   = 32;
    localparam int FREQ_W   = 32;
    localparam int PROD_W   = CPU_HZ_W + EDGE_W;

    localparam logic [CPU_HZ_W-1:0] CPU_HZ_RESET = 27'd16000000;
    localparam logic [WIN_W-1:0]    WINDOW_RESET = 16'd1000;

    // Configuration register indexes.
    localparam logic CFG_CPU_HZ = 1'b0;
    localparam logic CFG_WINDOW = 1'b1;

    // Event kinds.
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_WRAP  = 2'd2;
    localparam logic [1:0] FUNC_EDGE  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] capture_stamp;
    } ev_t;

    typedef struct packed {
        logic [1:0]        mode;
        logic              done_res;
        logic [EDGE_W-1:0] edge_total;
        logic [TICK_W-1:0] tick_total;
        logic [FREQ_W-1:0] freq_q16;
    } res_t;

    // Outcome of one event from the tracker.
    typedef struct packed {
        logic [1:0]        mode;
        logic              done;
        logic [EDGE_W-1:0] edges;
        logic [TICK_W-1:0] ticks;
    } trk_t;

endpackage

// File: rtl/grfc_track.sv
// Event tracker: gate window, phase, edge and overflow counters, stamps.
module grfc_track #(
    parameter int TIMER_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  grfc_pkg::ev_t               ev,
    input  logic [grfc_pkg::WIN_W-1:0]  window_ticks,
    output grfc_pkg::trk_t              trk
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PENDING = 2'd1,
        PH_RUNNING = 2'd2
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [grfc_pkg::WIN_W-1:0]    tick_reg, tick_next, tick_inc;
    logic                          flag_reg, flag_next;
    logic [TIMER_BITS-1:0]         first_reg, first_next;
    logic [15:0]                   wrap_reg, wrap_next;
    logic [grfc_pkg::EDGE_W-1:0]   edge_reg, edge_next;
    logic [TIMER_BITS-1:0]         stamp;
    logic                          done;
    logic [grfc_pkg::TICK_W-1:0]   span;

    assign stamp    = ev.capture_stamp[TIMER_BITS-1:0];
    assign tick_inc = tick_reg + 1'b1;
    assign span     = grfc_pkg::TICK_W'(wrap_reg) << TIMER_BITS;

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        flag_next  = flag_reg;
        first_next = first_reg;
        wrap_next  = wrap_reg;
        edge_next  = edge_reg;
        done       = 1'b0;
        case (ev.func)
            grfc_pkg::FUNC_START:
            begin
                flag_next  = 1'b0;
                phase_next = PH_PENDING;
            end
            grfc_pkg::FUNC_TICK:
            begin
                if (tick_inc == window_ticks)
                begin
                    flag_next = 1'b1;
                    tick_next = '0;
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
            grfc_pkg::FUNC_WRAP:
            begin
                wrap_next = wrap_reg + 1'b1;
            end
            grfc_pkg::FUNC_EDGE:
            begin
                if (phase_reg == PH_PENDING && flag_reg)
                begin
                    first_next = stamp;
                    wrap_next  = '0;
                    edge_next  = '0;
                    flag_next  = 1'b0;
                    phase_next = PH_RUNNING;
                end
                else if (phase_reg == PH_RUNNING)
                begin
                    edge_next = edge_reg + 1'b1;
                    if (flag_reg)
                    begin
                        flag_next  = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        trk.mode  = phase_next;
        trk.done  = done;
        trk.edges = done ? edge_next : '0;
        trk.ticks = done ? (span + grfc_pkg::TICK_W'(stamp) - grfc_pkg::TICK_W'(first_reg))
                         : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            flag_reg  <= 1'b0;
            first_reg <= '0;
            wrap_reg  <= '0;
            edge_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            flag_reg  <= flag_next;
            first_reg <= first_next;
            wrap_reg  <= wrap_next;
            edge_reg  <= edge_next;
        end
    end

endmodule

// File: rtl/grfc_mul.sv
// Bit-serial shift-add multiplier: cpu_hz times edge count, one bit per cycle.
module grfc_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [grfc_pkg::CPU_HZ_W-1:0]   mcand,
    input  logic [grfc_pkg::EDGE_W-1:0]     mplier,
    output logic                            done,
    output logic [grfc_pkg::PROD_W-1:0]     prod
);

    localparam int CNT_W = $clog2(grfc_pkg::EDGE_W);

    logic                            busy_reg;
    logic                            done_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [grfc_pkg::PROD_W-1:0]     prod_reg;
    logic [grfc_pkg::CPU_HZ_W:0]     sum;
    logic                            last_bit;

    // Add into the upper part, then shift the whole product right.
    assign sum = {1'b0, prod_reg[grfc_pkg::PROD_W-1:grfc_pkg::EDGE_W]}
               + (prod_reg[0] ? {1'b0, mcand} : '0);

    assign last_bit = (cnt_reg == CNT_W'(grfc_pkg::EDGE_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && last_bit;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_bit)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= {{grfc_pkg::CPU_HZ_W{1'b0}}, mplier};
        end
        else if (busy_reg)
        begin
            prod_reg <= {sum, prod_reg[grfc_pkg::EDGE_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// File: rtl/grfc_div.sv
// Restoring divider: (prod << 16) / ticks, one quotient bit per cycle, saturating.
module grfc_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [grfc_pkg::PROD_W-1:0]     prod,
    input  logic [grfc_pkg::TICK_W-1:0]     den,
    output logic                            done,
    output logic [grfc_pkg::FREQ_W-1:0]     quot
);

    localparam int LO_W  = grfc_pkg::EDGE_W;
    localparam int HI_W  = grfc_pkg::PROD_W - LO_W;
    localparam int CNT_W = $clog2(grfc_pkg::FREQ_W);

    logic                            busy_reg;
    logic                            done_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [grfc_pkg::TICK_W-1:0]     rem_reg;
    logic [grfc_pkg::FREQ_W-1:0]     sh_reg;
    logic [grfc_pkg::TICK_W:0]       trial;
    logic [grfc_pkg::TICK_W:0]       diff;
    logic                            fits;
    logic                            sat;
    logic                            zero_den;
    logic                            last_bit;

    assign zero_den = (den == '0);
    // Quotient overflows 32 bits when the upper numerator already reaches the divisor.
    assign sat      = (grfc_pkg::TICK_W'(prod[grfc_pkg::PROD_W-1:LO_W]) >= den);
    assign trial    = {rem_reg, sh_reg[grfc_pkg::FREQ_W-1]};
    assign diff     = trial - {1'b0, den};
    assign fits     = (trial >= {1'b0, den});
    assign last_bit = (cnt_reg == CNT_W'(grfc_pkg::FREQ_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= start ? (zero_den || sat) : (busy_reg && last_bit);
            if (start)
            begin
                cnt_reg <= '0;
                if (!zero_den && !sat)
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_bit)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= grfc_pkg::TICK_W'(prod[grfc_pkg::PROD_W-1:LO_W]);
            if (zero_den)
            begin
                sh_reg <= '0;
            end
            else if (sat)
            begin
                sh_reg <= '1;
            end
            else
            begin
                sh_reg <= {prod[LO_W-1:0], {(grfc_pkg::FREQ_W - LO_W){1'b0}}};
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[grfc_pkg::TICK_W-1:0] : trial[grfc_pkg::TICK_W-1:0];
            sh_reg  <= {sh_reg[grfc_pkg::FREQ_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

    // Unused high bit check: HI_W bits of numerator feed the remainder.
    initial_width_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (HI_W <= grfc_pkg::TICK_W))
        else $error("numerator upper part wider than divisor");

endmodule

// File: rtl/gated_reciprocal_frequency_counter.sv
// Top level of the gated reciprocal frequency counter.
//
//  channel | signals                              | moves
//  --------+--------------------------------------+---------------------------
//  ev      | ev_valid, ev_ready, ev_item (ev_t)   | one event item in
//  res     | res_valid, res_ready, res_item       | one result item per event
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register write, always ready
//
//  Events that do not close a window: result is valid in the cycle after accept.
//  Window-closing edge: the bit-serial multiplier runs and hands off to the
//  bit-serial divider (which skips its bit loop when ticks are zero or the result
//  saturates), then the result register is loaded once the output register is free.
//  One item is in work at a time; the next item enters only while the output
//  register is empty or its item leaves in the same cycle, and a closing edge
//  holds ev_ready low until its result is loaded. Reset clears all counters
//  and phase to idle.
module gated_reciprocal_frequency_counter #(
    parameter int TIMER_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            ev_valid,
    output logic                            ev_ready,
    input  grfc_pkg::ev_t                   ev_item,
    output logic                            res_valid,
    input  logic                            res_ready,
    output grfc_pkg::res_t                  res_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [grfc_pkg::CPU_HZ_W-1:0]   cfg_data
);

    typedef enum logic [1:0] {
        ST_READY,
        ST_MUL,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t                            state_reg;
    logic                              res_valid_reg;
    grfc_pkg::res_t                    res_reg;
    grfc_pkg::trk_t                    pend_reg;
    logic [grfc_pkg::CPU_HZ_W-1:0]     cpu_hz_reg;
    logic [grfc_pkg::WIN_W-1:0]        window_reg;

    grfc_pkg::trk_t                    trk;
    logic                              ev_accept;
    logic                              res_free;
    logic                              load_res;
    logic                              mul_done;
    logic [grfc_pkg::PROD_W-1:0]       prod;
    logic                              div_done;
    logic [grfc_pkg::FREQ_W-1:0]       quot;

    assign res_free  = !res_valid_reg || res_ready;
    assign ev_ready  = (state_reg == ST_READY) && res_free;
    assign ev_accept = ev_valid && ev_ready;
    assign load_res  = (ev_accept && !trk.done) || (state_reg == ST_HOLD && res_free);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    grfc_track #(
        .TIMER_BITS (TIMER_BITS)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (ev_accept),
        .ev           (ev_item),
        .window_ticks (window_reg),
        .trk          (trk)
    );

    grfc_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ev_accept && trk.done),
        .mcand  (cpu_hz_reg),
        .mplier (trk.edges),
        .done   (mul_done),
        .prod   (prod)
    );

    grfc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_done),
        .prod  (prod),
        .den   (pend_reg.ticks),
        .done  (div_done),
        .quot  (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_hz_reg <= grfc_pkg::CPU_HZ_RESET;
            window_reg <= grfc_pkg::WINDOW_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                grfc_pkg::CFG_CPU_HZ: cpu_hz_reg <= cfg_data;
                grfc_pkg::CFG_WINDOW: window_reg <= cfg_data[grfc_pkg::WIN_W-1:0];
                default:              cpu_hz_reg <= cpu_hz_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_READY:
                begin
                    if (ev_accept && trk.done)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    // Wait for the output register to drain, then load the result.
                    if (res_free)
                    begin
                        state_reg <= ST_READY;
                    end
                end
                default:
                begin
                    state_reg <= ST_READY;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_accept)
        begin
            pend_reg            <= trk;
            res_reg.mode        <= trk.mode;
            res_reg.done_res    <= trk.done;
            res_reg.edge_total  <= trk.edges;
            res_reg.tick_total  <= trk.ticks;
            res_reg.freq_q16    <= '0;
        end
        else if (state_reg == ST_HOLD && res_free)
        begin
            res_reg.mode        <= pend_reg.mode;
            res_reg.done_res    <= pend_reg.done;
            res_reg.edge_total  <= pend_reg.edges;
            res_reg.tick_total  <= pend_reg.ticks;
            res_reg.freq_q16    <= quot;
        end
    end

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_READY) |-> !ev_ready)
        else $error("item accepted while a measurement is in work");

    a_closing_edge_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_accept && trk.done) |=> (state_reg == ST_MUL))
        else $error("closing edge did not start the multiplier");

    a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside its state");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside its state");

    a_plain_result_no_freq: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_accept && !trk.done) |=> (res_valid && !res_item.done_res
                                      && res_item.freq_q16 == '0))
        else $error("non-closing event produced a measurement");

endmodule

// File: dv/gated_reciprocal_frequency_counter_tb.sv
// Self-checking testbench for the gated reciprocal frequency counter.
`timescale 1ns / 1ps

module gated_reciprocal_frequency_counter_tb;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          ITEMS_PER_SETTING = 320;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PENDING = 2'd1,
        PH_RUNNING = 2'd2
    } meas_phase_t;

    typedef struct {
        bit                            is_write;
        logic                          reg_idx;
        logic [grfc_pkg::CPU_HZ_W-1:0] reg_val;
        grfc_pkg::ev_t                 ev;
        bit                            typed;
        grfc_pkg::res_t                want;
    } plan_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          ev_valid = 1'b0;
    logic                          ev_ready;
    grfc_pkg::ev_t                 ev_item = '0;
    logic                          res_valid;
    logic                          res_ready = 1'b0;
    grfc_pkg::res_t                res_item;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic                          cfg_index = 1'b0;
    logic [grfc_pkg::CPU_HZ_W-1:0] cfg_data = '0;

    // Shadow of the counter: configuration and measurement state.
    logic [grfc_pkg::CPU_HZ_W-1:0] cpu_hz_cfg = grfc_pkg::CPU_HZ_RESET;
    logic [grfc_pkg::WIN_W-1:0]    window_cfg = grfc_pkg::WINDOW_RESET;
    meas_phase_t                   meas_phase = PH_IDLE;
    logic [15:0]                   gate_ticks = '0;
    logic                          gate_open = 1'b0;
    logic [15:0]                   first_stamp_q = '0;
    logic [15:0]                   last_stamp_q = '0;
    logic [15:0]                   overflow_cnt = '0;
    logic [15:0]                   edge_cnt = '0;

    grfc_pkg::res_t due_reports[$];
    plan_row_t      plan[$];
    grfc_pkg::res_t head;
    int             fail_count = 0;
    int             sent = 0;
    bit             offering = 1'b0;
    int             send_idle_pct = 34;
    int             recv_idle_pct = 75;
    int             hold_req = 0;
    int             hold_seen = 0;
    int             hold_left = 0;
    int unsigned    cycle_count = 0;

    gated_reciprocal_frequency_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev_item   (ev_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Advance the shadow by one event and return the status it reports.
    function automatic grfc_pkg::res_t count_event(grfc_pkg::ev_t ev);
        grfc_pkg::res_t r;
        logic [63:0]    span;
        logic [63:0]    num;
        logic [63:0]    quo;
        logic [31:0]    ticks;
        r = '0;
        case (ev.func)
            grfc_pkg::FUNC_START:
            begin
                gate_open  = 1'b0;
                meas_phase = PH_PENDING;
            end
            grfc_pkg::FUNC_TICK:
            begin
                gate_ticks = gate_ticks + 16'd1;
                if (gate_ticks == window_cfg)
                begin
                    gate_open  = 1'b1;
                    gate_ticks = '0;
                end
            end
            grfc_pkg::FUNC_WRAP:
                overflow_cnt = overflow_cnt + 16'd1;
            default:
            begin
                if (meas_phase == PH_PENDING && gate_open)
                begin
                    first_stamp_q = ev.capture_stamp;
                    last_stamp_q  = ev.capture_stamp;
                    overflow_cnt  = '0;
                    edge_cnt      = '0;
                    gate_open     = 1'b0;
                    meas_phase    = PH_RUNNING;
                end
                else if (meas_phase == PH_RUNNING)
                begin
                    last_stamp_q = ev.capture_stamp;
                    edge_cnt     = edge_cnt + 16'd1;
                    if (gate_open)
                    begin
                        gate_open  = 1'b0;
                        meas_phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
            end
        endcase
        if (r.done_res)
        begin
            span  = {32'h0, overflow_cnt, 16'h0} + {48'h0, last_stamp_q}
                    - {48'h0, first_stamp_q};
            ticks = span[31:0];
            r.edge_total = edge_cnt;
            r.tick_total = ticks;
            if (ticks != 0)
            begin
                num = {37'h0, cpu_hz_cfg} * {48'h0, edge_cnt};
                num = num << 16;
                quo = num / {32'h0, ticks};
                r.freq_q16 = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
            end
        end
        r.mode = meas_phase;
        return r;
    endfunction

    function automatic grfc_pkg::res_t mk_res(meas_phase_t m, logic d, logic [15:0] e,
                                              logic [31:0] t, logic [31:0] f);
        grfc_pkg::res_t r;
        r.mode       = m;
        r.done_res   = d;
        r.edge_total = e;
        r.tick_total = t;
        r.freq_q16   = f;
        return r;
    endfunction

    function automatic void plan_chk(logic [1:0] f, logic [15:0] s, bit typed,
                                     grfc_pkg::res_t want);
        plan_row_t row;
        row.is_write = 1'b0;
        row.reg_idx  = 1'b0;
        row.reg_val  = '0;
        row.ev.func  = f;
        row.ev.capture_stamp = s;
        row.typed    = typed;
        row.want     = want;
        plan.push_back(row);
    endfunction

    function automatic void plan_cfg(logic idx, logic [grfc_pkg::CPU_HZ_W-1:0] v);
        plan_row_t row;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = v;
        row.ev       = '0;
        row.typed    = 1'b0;
        row.want     = '0;
        plan.push_back(row);
    endfunction

    function automatic logic [15:0] pick_stamp();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Offer one item, hold it until accepted, then log what it should report.
    task automatic offer_event(grfc_pkg::ev_t ev, bit typed, grfc_pkg::res_t want);
        grfc_pkg::res_t r;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            if (offering)
                ev_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        ev_valid <= 1'b1;
        ev_item  <= ev;
        offering = 1'b1;
        @(posedge clk);
        while (!ev_ready)
            @(posedge clk);
        r = count_event(ev);
        due_reports.push_back(typed ? want : r);
        sent++;
    endtask

    task automatic post_event(logic [1:0] f, logic [15:0] s);
        grfc_pkg::ev_t ev;
        ev.func = f;
        ev.capture_stamp = s;
        offer_event(ev, 1'b0, '0);
    endtask

    task automatic drain();
        if (offering)
            ev_valid <= 1'b0;
        offering = 1'b0;
        while (due_reports.size() != 0)
            @(posedge clk);
    endtask

    // Keep valid up when another write follows right away.
    task automatic write_reg(logic idx, logic [grfc_pkg::CPU_HZ_W-1:0] val, bit last_write);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (last_write)
            cfg_valid <= 1'b0;
        if (idx == grfc_pkg::CFG_CPU_HZ)
            cpu_hz_cfg = val;
        else
            window_cfg = val[grfc_pkg::WIN_W-1:0];
    endtask

    task automatic run_measurement();
        int n;
        post_event(grfc_pkg::FUNC_START, pick_stamp());
        while (!gate_open)
        begin
            case ($urandom_range(0, 5))
                0:       post_event(grfc_pkg::FUNC_WRAP, pick_stamp());
                1:       post_event(grfc_pkg::FUNC_EDGE, pick_stamp());
                default: post_event(grfc_pkg::FUNC_TICK, pick_stamp());
            endcase
        end
        // Occasionally restart right before the opening edge.
        if ($urandom_range(0, 9) == 0)
            post_event(grfc_pkg::FUNC_START, pick_stamp());
        post_event(grfc_pkg::FUNC_EDGE, pick_stamp());
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0, 1: post_event(grfc_pkg::FUNC_EDGE, pick_stamp());
                2:    repeat ($urandom_range(1, 3))
                          post_event(grfc_pkg::FUNC_WRAP, pick_stamp());
                default: post_event(grfc_pkg::FUNC_TICK, pick_stamp());
            endcase
        end
        // Drop the measurement in progress now and then.
        if ($urandom_range(0, 11) == 0)
            post_event(grfc_pkg::FUNC_START, pick_stamp());
        if (meas_phase == PH_RUNNING)
        begin
            while (!gate_open)
                post_event(grfc_pkg::FUNC_TICK, pick_stamp());
            post_event(grfc_pkg::FUNC_EDGE, pick_stamp());
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            res_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end
        else
            res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (due_reports.size() == 0)
            begin
                fail_count++;
                $error("result item with no event outstanding");
            end
            else
            begin
                head = due_reports.pop_front();
                check_field("mode", head.mode, res_item.mode);
                check_field("done_res", head.done_res, res_item.done_res);
                check_field("edge_total", head.edge_total, res_item.edge_total);
                check_field("tick_total", head.tick_total, res_item.tick_total);
                check_field("freq_q16", head.freq_q16, res_item.freq_q16);
            end
        end
    end

    initial
    begin
        logic [grfc_pkg::CPU_HZ_W-1:0] hz_list[6];
        logic [grfc_pkg::WIN_W-1:0]    win_list[6];
        logic [grfc_pkg::CPU_HZ_W-1:0] hz;
        logic [grfc_pkg::WIN_W-1:0]    win;
        int                            target;

        hz_list  = '{27'd16000000, 27'd1, 27'd100000000, 27'd67108863, 27'd0, 27'd12345678};
        win_list = '{16'd3, 16'd1, 16'd5, 16'd2, 16'd0, 16'd65535};

        // Reset state: stray edges and overflows leave the block idle.
        plan_chk(grfc_pkg::FUNC_EDGE, 16'hFFFF, 1'b1, mk_res(PH_IDLE, 1'b0, '0, '0, '0));
        plan_chk(grfc_pkg::FUNC_WRAP, 16'h0000, 1'b1, mk_res(PH_IDLE, 1'b0, '0, '0, '0));
        plan_chk(grfc_pkg::FUNC_START, 16'hFFFF, 1'b1,
                 mk_res(PH_PENDING, 1'b0, '0, '0, '0));
        // Edge while pending without the window flag is ignored.
        plan_chk(grfc_pkg::FUNC_EDGE, 16'h0000, 1'b1,
                 mk_res(PH_PENDING, 1'b0, '0, '0, '0));
        plan_cfg(grfc_pkg::CFG_WINDOW, 27'd1);
        plan_cfg(grfc_pkg::CFG_CPU_HZ, 27'd1);
        plan_chk(grfc_pkg::FUNC_TICK, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_EDGE, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_EDGE, 16'hFFFF, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_WRAP, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_TICK, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_EDGE, 16'h1234, 1'b0, '0);
        // Same stamp at both ends: zero ticks, zero frequency.
        plan_chk(grfc_pkg::FUNC_START, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_TICK, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_EDGE, 16'h5555, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_TICK, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_EDGE, 16'h5555, 1'b1,
                 mk_res(PH_IDLE, 1'b1, 16'd1, '0, '0));
        // One tick at the top rate: frequency saturates.
        plan_cfg(grfc_pkg::CFG_CPU_HZ, 27'd100000000);
        plan_chk(grfc_pkg::FUNC_START, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_TICK, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_EDGE, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_TICK, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_EDGE, 16'h0001, 1'b1,
                 mk_res(PH_IDLE, 1'b1, 16'd1, 32'd1, 32'hFFFF_FFFF));
        // Start while running drops the measurement.
        plan_chk(grfc_pkg::FUNC_START, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_TICK, 16'h0000, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_EDGE, 16'hAAAA, 1'b0, '0);
        plan_chk(grfc_pkg::FUNC_START, 16'h0000, 1'b1,
                 mk_res(PH_PENDING, 1'b0, '0, '0, '0));
        plan_chk(grfc_pkg::FUNC_EDGE, 16'h5555, 1'b1,
                 mk_res(PH_PENDING, 1'b0, '0, '0, '0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < plan.size(); i++)
        begin
            if (plan[i].is_write)
                write_reg(plan[i].reg_idx, plan[i].reg_val,
                          !(i + 1 < plan.size() && plan[i + 1].is_write));
            else
                offer_event(plan[i].ev, plan[i].typed, plan[i].want);
        end

        for (int s = 0; s < 6; s++)
        begin
            send_idle_pct = (s < 2) ? 34 : (s < 4) ? 75 : 0;
            recv_idle_pct <= (s < 2) ? 75 : (s < 4) ? 34 : 0;
            hz  = (hz_list[s] == 0) ? grfc_pkg::CPU_HZ_W'($urandom_range(1, 100000000))
                                    : hz_list[s];
            win = (win_list[s] == 0) ? grfc_pkg::WIN_W'($urandom_range(1, 12)) : win_list[s];
            // Bring the gating counter back to zero so a shorter window still fires.
            while (window_cfg <= 64 && gate_ticks != 0)
                post_event(grfc_pkg::FUNC_TICK, pick_stamp());
            write_reg(grfc_pkg::CFG_CPU_HZ, hz, 1'b0);
            write_reg(grfc_pkg::CFG_WINDOW, grfc_pkg::CPU_HZ_W'(win), 1'b1);
            if (s == 1)
                hold_req <= hold_req + 1;
            target = sent + ITEMS_PER_SETTING;
            while (sent < target)
            begin
                if (window_cfg <= 64 && $urandom_range(0, 4) != 0)
                    run_measurement();
                else
                    repeat ($urandom_range(1, 4))
                        post_event(2'($urandom_range(0, 3)), pick_stamp());
            end
        end

        drain();
        repeat (80) @(posedge clk);
        if (fail_count == 0 && due_reports.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
rtl/grfc_pkg.sv
rtl/grfc_track.sv
rtl/grfc_mul.sv
rtl/grfc_div.sv
rtl/gated_reciprocal_frequency_counter.sv
dv/gated_reciprocal_frequency_counter_tb.sv
